### design/ede_pkg.sv
// Shared types and constants for the ext2 directory entry scanner.
package ede_pkg;

  localparam int unsigned HEADER_BYTES = 8;

  // result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
  localparam logic [1:0] REG_HAS_FILE_TYPE   = 2'd1;

  localparam logic [1:0] REC_ALIGN_MASK = 2'b11;

  localparam logic [4:0] LOG2_MIN = 5'd10;
  localparam logic [4:0] LOG2_MAX = 5'd16;

  typedef struct packed {
    logic [4:0] block_size_log2;
    logic       has_file_type;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] inode_number;
    logic [15:0] record_length;
    logic [7:0]  name_length;
    logic [7:0]  file_type;
    logic [15:0] entry_offset;
    logic [7:0]  name_char;
    logic        last_of_entry;
  } result_t;

endpackage

### design/ede_front.sv
// Input side: accepts bytes and holds them in a short queue for the scanner.
module ede_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ede_pkg::item_t item_i,
  output logic           item_valid_o,
  input  logic           item_pop_i,
  output ede_pkg::item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ede_pkg::item_t slots_q [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign in_stall_o   = (count_q == CNT_FULL);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### design/ede_back.sv
// Scanner: walks the directory block byte by byte and registers the results.
module ede_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ede_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  ede_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ede_pkg::result_t res_o
);

  localparam logic [16:0] HDR_17 = 17'(ede_pkg::HEADER_BYTES);
  localparam logic [15:0] HDR_16 = 16'(ede_pkg::HEADER_BYTES);
  localparam logic [3:0]  HDR_4  = 4'(ede_pkg::HEADER_BYTES);

  logic [16:0] off_q, off_d;
  logic [15:0] start_q, start_d;
  logic [55:0] hdr_q, hdr_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  name_q, name_d;
  logic [15:0] skip_q, skip_d;
  logic        stop_q, stop_d;

  logic             out_valid_q, out_valid_d;
  ede_pkg::result_t res_q, res_d;

  // state as seen by this byte, after a block restart
  logic [16:0] off_e;
  logic [15:0] start_e;
  logic [3:0]  cnt_e;
  logic [7:0]  name_e;
  logic [15:0] skip_e;
  logic        stop_e;

  logic [4:0]       lg;
  logic [16:0]      bs;
  logic [7:0]       b;
  logic [31:0]      ino;
  logic [15:0]      rec;
  logic [7:0]       nl;
  logic             bad;
  logic             emit;
  logic             advance;
  logic             next_entry;
  ede_pkg::result_t res;

  assign advance    = !out_valid_q || !out_stall_i;
  assign item_pop_o = item_valid_i && advance;

  assign b   = item_i.data_byte;
  assign ino = hdr_q[31:0];
  assign rec = hdr_q[47:32];
  assign nl  = hdr_q[55:48];

  always_comb begin
    if (cfg_i.block_size_log2 < ede_pkg::LOG2_MIN) begin
      lg = ede_pkg::LOG2_MIN;
    end else if (cfg_i.block_size_log2 > ede_pkg::LOG2_MAX) begin
      lg = ede_pkg::LOG2_MAX;
    end else begin
      lg = cfg_i.block_size_log2;
    end
    bs = 17'(1) << lg;
  end

  assign bad = (rec < HDR_16) || ((rec[1:0] & ede_pkg::REC_ALIGN_MASK) != 2'b00) ||
               ((17'(start_e) + 17'(rec)) > bs) || ((16'(nl) + HDR_16) > rec);

  always_comb begin
    if (item_i.first_byte) begin
      off_e   = '0;
      start_e = '0;
      cnt_e   = '0;
      name_e  = '0;
      skip_e  = '0;
      stop_e  = 1'b0;
    end else begin
      off_e   = off_q;
      start_e = start_q;
      cnt_e   = cnt_q;
      name_e  = name_q;
      skip_e  = skip_q;
      stop_e  = stop_q;
    end

    off_d      = off_e;
    start_d    = start_e;
    hdr_d      = hdr_q;
    cnt_d      = cnt_e;
    name_d     = name_e;
    skip_d     = skip_e;
    stop_d     = stop_e;
    emit       = 1'b0;
    next_entry = 1'b0;
    res        = '0;

    if (!stop_e && (off_e < bs)) begin
      off_d = off_e + 17'(1);
      if (cnt_e < HDR_4) begin
        if ((cnt_e == 4'd0) && ((18'(off_e) + 18'(HDR_17)) > 18'(bs))) begin
          // short tail: quiet end of block
          stop_d = 1'b1;
        end else begin
          cnt_d = cnt_e + 4'd1;
          if (cnt_e[2:0] != 3'd7) begin
            hdr_d[{cnt_e[2:0], 3'b000} +: 8] = b;
          end else begin
            res.entry_offset = start_e;
            if (bad) begin
              res.kind          = ede_pkg::KIND_STOP;
              res.record_length = rec;
              emit              = 1'b1;
              stop_d            = 1'b1;
            end else if (ino != 32'd0) begin
              res.kind          = ede_pkg::KIND_ENTRY;
              res.inode_number  = ino;
              res.record_length = rec;
              res.name_length   = nl;
              res.file_type     = cfg_i.has_file_type ? b : 8'd0;
              res.last_of_entry = (nl == 8'd0);
              emit              = 1'b1;
              name_d            = nl;
              skip_d            = rec - HDR_16 - 16'(nl);
              next_entry        = (nl == 8'd0) && (rec == HDR_16 + 16'(nl));
            end else begin
              name_d     = 8'd0;
              skip_d     = rec - HDR_16;
              next_entry = (rec == HDR_16);
            end
          end
        end
      end else if (name_e != 8'd0) begin
        name_d            = name_e - 8'd1;
        res.kind          = ede_pkg::KIND_NAME;
        res.entry_offset  = start_e;
        res.name_char     = b;
        res.last_of_entry = (name_e == 8'd1);
        emit              = 1'b1;
        next_entry        = (name_e == 8'd1) && (skip_e == 16'd0);
      end else if (skip_e != 16'd0) begin
        skip_d     = skip_e - 16'd1;
        next_entry = (skip_e == 16'd1);
      end else begin
        next_entry = 1'b1;
      end
      if (next_entry) begin
        cnt_d   = '0;
        start_d = off_e[15:0] + 16'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (item_pop_o) begin
      out_valid_d = emit;
      res_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q       <= '0;
      start_q     <= '0;
      cnt_q       <= '0;
      name_q      <= '0;
      skip_q      <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (item_pop_o) begin
        off_q   <= off_d;
        start_q <= start_d;
        cnt_q   <= cnt_d;
        name_q  <= name_d;
        skip_q  <= skip_d;
        stop_q  <= stop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (item_pop_o) begin
      hdr_q <= hdr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

### design/ext2_dir_entry_scanner.sv
// Top level of the ext2 directory entry scanner: queue, scanner and config registers.
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  data_byte_i, first_byte_i
//  out      output     out_valid_o/out_stall_i kind_o .. last_of_entry_o
//  cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through a queue slot, then the scanner output register, after its byte is taken.
// The queue holds QUEUE_DEPTH items, so input runs on while the output stalls
// until the queue fills; the scanner waits only when its output register is
// full and stalled. Reset clears the scan state and sets block size 1024 with
// file types reported; no clearing pass is needed.
module ext2_dir_entry_scanner #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] inode_number_o,
  output logic [15:0] record_length_o,
  output logic [7:0]  name_length_o,
  output logic [7:0]  file_type_o,
  output logic [15:0] entry_offset_o,
  output logic [7:0]  name_char_o,
  output logic        last_of_entry_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  ede_pkg::cfg_t    cfg_q;
  ede_pkg::item_t   in_item;
  ede_pkg::item_t   q_item;
  ede_pkg::result_t res;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size_log2 <= ede_pkg::LOG2_MIN;
      cfg_q.has_file_type   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ede_pkg::REG_BLOCK_SIZE_LOG2: cfg_q.block_size_log2 <= cfg_data_i;
        ede_pkg::REG_HAS_FILE_TYPE:   cfg_q.has_file_type   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_item.data_byte  = data_byte_i;
  assign in_item.first_byte = first_byte_i;

  ede_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .item_i      (in_item),
    .item_valid_o(q_valid),
    .item_pop_i  (q_pop),
    .item_o      (q_item)
  );

  ede_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(q_valid),
    .item_i      (q_item),
    .item_pop_o  (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign inode_number_o  = res.inode_number;
  assign record_length_o = res.record_length;
  assign name_length_o   = res.name_length;
  assign file_type_o     = res.file_type;
  assign entry_offset_o  = res.entry_offset;
  assign name_char_o     = res.name_char;
  assign last_of_entry_o = res.last_of_entry;

endmodule

### design/ede_checker.sv
// Port-level checks for the directory entry scanner, bound to the top level.
module ede_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [31:0] inode_number_o,
  input logic [15:0] record_length_o,
  input logic [7:0]  name_length_o,
  input logic        last_of_entry_o
);

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(inode_number_o) && $stable(record_length_o))
    else $error("stalled output item changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o != 2'd3)
    else $error("undefined result kind");

  // a stop item carries only record length and offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ede_pkg::KIND_STOP |->
      !last_of_entry_o && inode_number_o == 32'd0 && name_length_o == 8'd0)
    else $error("malformed stop item carries entry fields");

  // an entry header always has a nonzero inode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ede_pkg::KIND_ENTRY |-> inode_number_o != 32'd0)
    else $error("entry header with inode zero");

endmodule

bind ext2_dir_entry_scanner ede_checker u_ede_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o),
  .inode_number_o (inode_number_o),
  .record_length_o(record_length_o),
  .name_length_o  (name_length_o),
  .last_of_entry_o(last_of_entry_o)
);

### bench/ext2_dir_entry_scanner_tb.sv
// Self-checking bench for the ext2 directory entry scanner: byte stream in, entry items out.
module ext2_dir_entry_scanner_tb;

  localparam int unsigned CYCLE_LIMIT = 60000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] inode_number_o;
  logic [15:0] record_length_o;
  logic [7:0]  name_length_o;
  logic [7:0]  file_type_o;
  logic [15:0] entry_offset_o;
  logic [7:0]  name_char_o;
  logic        last_of_entry_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  ext2_dir_entry_scanner dut (.*);

  // stimulus and expected results
  ede_pkg::item_t   block_build[$];
  ede_pkg::item_t   byte_queue[$];
  ede_pkg::result_t due_records[$];

  // scanner state as the bench sees it
  logic [4:0]  cfg_log2 = 5'd10;
  logic        cfg_ft = 1'b1;
  logic [16:0] scan_pos = '0;
  logic [15:0] ent_off = '0;
  logic [63:0] hdr_buf = '0;
  int unsigned hdr_cnt = 0;
  logic [7:0]  name_rem = '0;
  logic [15:0] pad_rem = '0;
  bit          scan_done = 1'b0;

  int          idle_pct = 11;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  bit          byte_taken = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned blocks_seen = 0;
  int unsigned n_entries = 0;
  int unsigned n_names = 0;
  int unsigned n_stops = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void next_header(input int unsigned pos);
    hdr_cnt = 0;
    hdr_buf = '0;
    ent_off = 16'(pos + 1);
  endfunction

  // advances the scan by one byte; returns 1 when the byte yields an item
  function automatic bit walk_dir_byte(input logic [7:0] b, input logic fb,
                                       output ede_pkg::result_t r);
    int unsigned lim, pos, rec, nl;
    logic [31:0] ino;
    logic [4:0]  lg;
    bit          hit;
    r = '0;
    hit = 1'b0;
    if (fb) begin
      scan_pos = '0;
      ent_off = '0;
      hdr_buf = '0;
      hdr_cnt = 0;
      name_rem = '0;
      pad_rem = '0;
      scan_done = 1'b0;
    end
    lg = (cfg_log2 < ede_pkg::LOG2_MIN) ? ede_pkg::LOG2_MIN :
         ((cfg_log2 > ede_pkg::LOG2_MAX) ? ede_pkg::LOG2_MAX : cfg_log2);
    lim = 1 << lg;
    if (scan_done || scan_pos >= lim) return 1'b0;
    pos = scan_pos;
    if (hdr_cnt < ede_pkg::HEADER_BYTES) begin
      if (hdr_cnt == 0 && pos + ede_pkg::HEADER_BYTES > lim) begin
        scan_done = 1'b1;  // short tail, silent
      end else begin
        hdr_buf[8*hdr_cnt +: 8] = b;
        hdr_cnt++;
        if (hdr_cnt == ede_pkg::HEADER_BYTES) begin
          ino = hdr_buf[31:0];
          rec = 32'(hdr_buf[47:32]);
          nl = 32'(hdr_buf[55:48]);
          r.entry_offset = ent_off;
          if (rec < ede_pkg::HEADER_BYTES || (rec & ede_pkg::REC_ALIGN_MASK) != 0 ||
              ent_off + rec > lim || ede_pkg::HEADER_BYTES + nl > rec) begin
            r.kind = ede_pkg::KIND_STOP;
            r.record_length = 16'(rec);
            hit = 1'b1;
            scan_done = 1'b1;
          end else begin
            if (ino != 0) begin
              r.kind = ede_pkg::KIND_ENTRY;
              r.inode_number = ino;
              r.record_length = 16'(rec);
              r.name_length = 8'(nl);
              r.file_type = cfg_ft ? hdr_buf[63:56] : 8'd0;
              r.last_of_entry = (nl == 0);
              hit = 1'b1;
              name_rem = 8'(nl);
              pad_rem = 16'(rec - ede_pkg::HEADER_BYTES - nl);
            end else begin
              name_rem = '0;
              pad_rem = 16'(rec - ede_pkg::HEADER_BYTES);
            end
            if (name_rem == 0 && pad_rem == 0) next_header(pos);
          end
        end
      end
    end else if (name_rem != 0) begin
      name_rem--;
      r.kind = ede_pkg::KIND_NAME;
      r.entry_offset = ent_off;
      r.name_char = b;
      r.last_of_entry = (name_rem == 0);
      hit = 1'b1;
      if (name_rem == 0 && pad_rem == 0) next_header(pos);
    end else if (pad_rem != 0) begin
      pad_rem--;
      if (pad_rem == 0) next_header(pos);
    end else begin
      next_header(pos);
    end
    scan_pos = 17'(pos + 1);
    return hit;
  endfunction

  task automatic check_field(input string fld, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fld, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : scoreboard
    ede_pkg::result_t got, want, pred;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ede_pkg::REG_BLOCK_SIZE_LOG2: cfg_log2 = cfg_data_i;
          ede_pkg::REG_HAS_FILE_TYPE:   cfg_ft = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got = {kind_o, inode_number_o, record_length_o, name_length_o, file_type_o,
               entry_offset_o, name_char_o, last_of_entry_o};
        if (due_records.size() == 0) begin
          errors++;
          $display("%0t: item with none due, expected nothing, got kind %0d offset %0d",
                   $time, got.kind, got.entry_offset);
        end else begin
          want = due_records.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("inode_number", want.inode_number, got.inode_number);
          check_field("record_length", 32'(want.record_length), 32'(got.record_length));
          check_field("name_length", 32'(want.name_length), 32'(got.name_length));
          check_field("file_type", 32'(want.file_type), 32'(got.file_type));
          check_field("entry_offset", 32'(want.entry_offset), 32'(got.entry_offset));
          check_field("name_char", 32'(want.name_char), 32'(got.name_char));
          check_field("last_of_entry", 32'(want.last_of_entry), 32'(got.last_of_entry));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        bytes_taken++;
        if (first_byte_i) blocks_seen++;
        if (walk_dir_byte(data_byte_i, first_byte_i, pred)) begin
          due_records.push_back(pred);
          case (pred.kind)
            ede_pkg::KIND_ENTRY: n_entries++;
            ede_pkg::KIND_NAME:  n_names++;
            default:             n_stops++;
          endcase
        end
      end
    end
    byte_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // sender
  always @(negedge clk_i) begin : feeder
    ede_pkg::item_t nxt;
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = byte_queue.pop_front();
        data_byte_i <= nxt.data_byte;
        first_byte_i <= nxt.first_byte;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic stage_byte(input logic [7:0] b, input logic fb);
    ede_pkg::item_t it;
    it.data_byte = b;
    it.first_byte = fb;
    block_build.push_back(it);
  endtask

  task automatic stage_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) stage_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // header is little endian: inode, record length, name length, file type
  task automatic stage_header(input logic [31:0] ino, input logic [15:0] rec,
                              input logic [7:0] nl, input logic [7:0] ft,
                              input bit fb, input int unsigned keep);
    logic [63:0] h;
    h = {ft, nl, rec, ino};
    for (int unsigned k = 0; k < keep; k++) stage_byte(h[8*k +: 8], fb && k == 0);
  endtask

  task automatic release_bytes(input int unsigned n);
    int unsigned left;
    left = n;
    while (block_build.size() != 0 && left != 0) begin
      byte_queue.push_back(block_build.pop_front());
      left--;
    end
  endtask

  task automatic settle();
    while (byte_queue.size() != 0 || in_valid_i || due_records.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly well-formed entries, some malformed, some cut short by a new block, some random bytes
  task automatic stage_random_block(input int unsigned bs, input bit long_names);
    int unsigned off, n_ent, nl, rec, sel, pick, cut, big;
    logic [31:0] ino;
    off = 0;
    if (!long_names && $urandom_range(99) < 5) begin
      n_ent = $urandom_range(1, 40);
      for (int unsigned i = 0; i < n_ent; i++)
        stage_byte(8'($urandom_range(255)), $urandom_range(99) < 10);
      return;
    end
    n_ent = long_names ? $urandom_range(1, 2) : $urandom_range(1, 6);
    for (int unsigned e = 0; e < n_ent; e++) begin
      sel = $urandom_range(99);
      pick = $urandom_range(99);
      if (long_names) nl = $urandom_range(150, 255);
      else if (pick < 60) nl = $urandom_range(0, 12);
      else if (pick < 90) nl = $urandom_range(13, 40);
      else nl = $urandom_range(41, 255);
      rec = ((ede_pkg::HEADER_BYTES + nl + 3) / 4) * 4 + 4 * $urandom_range(0, 3);
      pick = $urandom_range(99);
      ino = (pick < 20) ? 32'd0 : (pick < 30) ? 32'hFFFF_FFFF : (pick < 35) ? 32'd1 : $urandom;
      if (!long_names && sel >= 85) begin
        case ($urandom_range(3))
          0: rec = 4 * $urandom_range(0, 1);
          1: rec = rec + $urandom_range(1, 3);
          2: begin
            big = (off < bs) ? bs - off + 4 : 32'hFFFF;
            rec = (big > 32'hFFFF) ? 32'hFFFF : big;
          end
          default: begin
            rec = 4 * $urandom_range(2, 61);
            nl = $urandom_range(rec - 7, 255);
          end
        endcase
        stage_header(ino, 16'(rec), 8'(nl), 8'($urandom_range(255)), e == 0,
                     ede_pkg::HEADER_BYTES);
        stage_bytes($urandom_range(0, 6));  // ignored after the stop
        return;
      end
      if ($urandom_range(99) < 10) begin
        cut = $urandom_range(1, rec - 1);
        if (cut < ede_pkg::HEADER_BYTES) begin
          stage_header(ino, 16'(rec), 8'(nl), 8'($urandom_range(255)), e == 0, cut);
        end else begin
          stage_header(ino, 16'(rec), 8'(nl), 8'($urandom_range(255)), e == 0,
                       ede_pkg::HEADER_BYTES);
          stage_bytes(cut - ede_pkg::HEADER_BYTES);
        end
        return;
      end
      stage_header(ino, 16'(rec), 8'(nl), 8'($urandom_range(255)), e == 0,
                   ede_pkg::HEADER_BYTES);
      stage_bytes(rec - ede_pkg::HEADER_BYTES);
      off += rec;
    end
  endtask

  // a whole 1 KiB block; the last header starts right at the short-tail limit, so the
  // block ends flush, then a few bytes past the end
  task automatic stage_full_block();
    int unsigned target, off, left, rec, nl;
    target = 1024 - ede_pkg::HEADER_BYTES;
    off = 0;
    while (off < target) begin
      left = target - off;
      rec = (left <= 264) ? left : 4 * $urandom_range(2, 64);
      nl = $urandom_range(0, (rec - ede_pkg::HEADER_BYTES < 40) ?
                             rec - ede_pkg::HEADER_BYTES : 40);
      stage_header(($urandom_range(3) == 0) ? 32'd0 : $urandom, 16'(rec), 8'(nl),
                   8'($urandom_range(255)), off == 0, ede_pkg::HEADER_BYTES);
      stage_bytes(rec - ede_pkg::HEADER_BYTES);
      off += rec;
    end
    stage_header(($urandom_range(3) == 0) ? 32'd0 : $urandom,
                 16'(ede_pkg::HEADER_BYTES), 8'd0, 8'($urandom_range(255)), 1'b0,
                 ede_pkg::HEADER_BYTES);
    stage_bytes(5);  // past the end
  endtask

  task automatic random_phase(input int unsigned n_bytes, input int unsigned bs);
    int unsigned sent;
    sent = 0;
    while (sent < n_bytes) begin
      stage_random_block(bs, 1'b0);
      sent += block_build.size();
      release_bytes(block_build.size());
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // no block start after reset: extreme inode and type, then an empty name
    stage_header(32'hFFFF_FFFF, 16'd12, 8'd2, 8'hFF, 1'b0, ede_pkg::HEADER_BYTES);
    stage_byte(8'h00, 1'b0);
    stage_byte(8'hFF, 1'b0);
    stage_bytes(2);
    stage_header(32'd1, 16'd8, 8'd0, 8'd0, 1'b0, ede_pkg::HEADER_BYTES);
    // record length below the header size, then bytes after the stop
    stage_header(32'd7, 16'd6, 8'd0, 8'd1, 1'b1, ede_pkg::HEADER_BYTES);
    stage_bytes(2);
    release_bytes(block_build.size());
    settle();

    set_reg(ede_pkg::REG_HAS_FILE_TYPE, 5'd0);
    set_reg(ede_pkg::REG_BLOCK_SIZE_LOG2, 5'd0);
    random_phase(80, 1024);

    // a stretch with no idling on either side
    set_reg(ede_pkg::REG_HAS_FILE_TYPE, 5'd1);
    set_reg(ede_pkg::REG_BLOCK_SIZE_LOG2, 5'd31);
    idle_pct = 0;
    random_phase(80, 65536);
    idle_pct = 11;

    // long names while the receiver holds off, so the input backs up
    set_reg(ede_pkg::REG_BLOCK_SIZE_LOG2, 5'd13);
    hold_req++;
    stage_random_block(8192, 1'b1);
    release_bytes(block_build.size());
    random_phase(50, 8192);

    set_reg(ede_pkg::REG_BLOCK_SIZE_LOG2, 5'd16);
    set_reg(ede_pkg::REG_HAS_FILE_TYPE, 5'd0);
    random_phase(80, 65536);

    // a full block with no idling; file type reporting flips part way through
    set_reg(ede_pkg::REG_BLOCK_SIZE_LOG2, 5'd10);
    set_reg(ede_pkg::REG_HAS_FILE_TYPE, 5'd1);
    idle_pct = 0;
    stage_full_block();
    release_bytes(500);
    settle();
    set_reg(ede_pkg::REG_HAS_FILE_TYPE, 5'd0);
    release_bytes(block_build.size());
    settle();
    idle_pct = 11;

    $display("covered %0d bytes over %0d blocks, six register settings incl. out-of-range sizes",
             bytes_taken, blocks_seen);
    $display("checked %0d entry headers, %0d name bytes and %0d malformed-entry stops",
             n_entries, n_names, n_stops);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/ede_pkg.sv
design/ede_front.sv
design/ede_back.sv
design/ext2_dir_entry_scanner.sv
design/ede_checker.sv
bench/ext2_dir_entry_scanner_tb.sv
